[sv/lzg_pkg.sv]
// shared types, constants and helpers of the lz77 greedy encoder
`timescale 1ns / 1ps
`default_nettype none

package lzg_pkg;

   localparam int WINDOW_MAX_DEFAULT = 256;
   localparam int BYTE_W             = 8;
   localparam int CFG_W              = 9;
   localparam int OUT_W              = 9;
   localparam int CFG_RESET          = 256;

   typedef enum logic [1:0] {
      S_IDLE,
      S_REDUCE,
      S_FINISH
   } lzg_state_type;

   typedef struct packed {
      logic              match;
      logic              first;
      logic              kill;
      logic              append;
      logic              shift;
      logic              clear;
      logic [BYTE_W-1:0] data;
   } lzg_cell_ctrl_type;

   // depth of the radix-4 reduction tree over the window cells
   function automatic int lzg_tree_levels(input int n);
      int lv;
      lv = ($clog2(n) + 1) >> 1;
      if (lv < 1) begin
         lv = 1;
      end
      return lv;
   endfunction

endpackage

`default_nettype wire

[sv/lzg_cell.sv]
// one window cell: stored byte, occupancy and match-end flag
`timescale 1ns / 1ps
`default_nettype none

module lzg_cell (
   input  wire                        clock,
   input  wire                        reset,
   input  lzg_pkg::lzg_cell_ctrl_type ctrl,
   input  wire [lzg_pkg::BYTE_W-1:0]  right_byte,
   input  wire                        right_occ,
   input  wire                        right_flag,
   input  wire                        left_occ,
   input  wire                        left_flag,
   output logic [lzg_pkg::BYTE_W-1:0] cell_byte,
   output logic                       cell_occ,
   output logic                       cell_flag
);
   import lzg_pkg::*;

   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              occ_ff, occ_in;
   logic              flag_ff, flag_in;

   always_comb begin
      byte_in = byte_ff;
      occ_in  = occ_ff;
      flag_in = flag_ff;
      priority if (ctrl.clear) begin
         occ_in  = 1'b0;
         flag_in = 1'b0;
      end else if (ctrl.match) begin
         flag_in = !ctrl.kill && occ_ff && (byte_ff == ctrl.data) &&
                   (ctrl.first || left_flag);
      end else if (ctrl.append) begin
         if (ctrl.shift) begin
            flag_in = right_flag;
            if (occ_ff && !right_occ) begin
               byte_in = ctrl.data;
            end else begin
               byte_in = right_byte;
            end
         end else if (!occ_ff && left_occ) begin
            byte_in = ctrl.data;
            occ_in  = 1'b1;
         end
      end else begin
         flag_in = flag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff  <= 1'b0;
         flag_ff <= 1'b0;
      end else begin
         occ_ff  <= occ_in;
         flag_ff <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign cell_byte = byte_ff;
   assign cell_occ  = occ_ff;
   assign cell_flag = flag_ff;

endmodule

`default_nettype wire

[sv/lzg_max_tree.sv]
// registered radix-4 tree finding the highest set flag
`timescale 1ns / 1ps
`default_nettype none

module lzg_max_tree #(
   parameter  int NUM_FLAGS = lzg_pkg::WINDOW_MAX_DEFAULT,
   localparam int LEVELS    = lzg_pkg::lzg_tree_levels(NUM_FLAGS),
   localparam int IDX_W     = 2 * LEVELS
) (
   input  wire                 clock,
   input  wire [NUM_FLAGS-1:0] flags,
   output logic                any_set,
   output logic [IDX_W-1:0]    top_idx
);
   import lzg_pkg::*;

   localparam int LEAVES = 1 << IDX_W;
   localparam int INNER  = (LEAVES - 1) / 3;

   logic             leaf_any [LEAVES];
   logic [3:0]       child_any [INNER];
   logic [IDX_W-1:0] child_idx [INNER][4];
   logic             node_any_ff [INNER];
   logic [IDX_W-1:0] node_idx_ff [INNER];
   logic             node_any_in [INNER];
   logic [IDX_W-1:0] node_idx_in [INNER];

   for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
      if (j < NUM_FLAGS) begin : g_real
         assign leaf_any[j] = flags[j];
      end else begin : g_pad
         assign leaf_any[j] = 1'b0;
      end
   end

   for (genvar i = 0; i < INNER; i++) begin : g_node
      for (genvar k = 0; k < 4; k++) begin : g_child
         localparam int C = 4 * i + k + 1;
         if (C >= INNER) begin : g_from_leaf
            assign child_any[i][k] = leaf_any[C-INNER];
            assign child_idx[i][k] = IDX_W'(C - INNER);
         end else begin : g_from_node
            assign child_any[i][k] = node_any_ff[C];
            assign child_idx[i][k] = node_idx_ff[C];
         end
      end

      always_comb begin
         node_any_in[i] = |child_any[i];
         priority if (child_any[i][3]) begin
            node_idx_in[i] = child_idx[i][3];
         end else if (child_any[i][2]) begin
            node_idx_in[i] = child_idx[i][2];
         end else if (child_any[i][1]) begin
            node_idx_in[i] = child_idx[i][1];
         end else begin
            node_idx_in[i] = child_idx[i][0];
         end
      end

      always_ff @(posedge clock) begin
         node_any_ff[i] <= node_any_in[i];
         node_idx_ff[i] <= node_idx_in[i];
      end
   end

   assign any_set = node_any_ff[0];
   assign top_idx = node_idx_ff[0];

endmodule

`default_nettype wire

[sv/lz77_greedy_encoder.sv]
// top level of the greedy lz77 encoder: control, window cells and match tree
//
// Byte stream in on req_* (valid/stall), tokens out on rsp_* (valid/stall).
// A transfer happens on a rising edge with valid high and stall low.
// Each byte goes through a row of WINDOW_MAX cells that holds the window;
// all cells compare the byte in the cycle it is taken, then a registered
// radix-4 tree, sized by LEVELS = ceil(log4(WINDOW_MAX)), finds the rightmost
// match end, and an append step adds the byte and may load a token into
// the output register.
// req_stall is high while an item is in work, so a new byte is taken
// only once the last one is through.
// A token is at most one per byte and appears on rsp_* the cycle after the
// append; it stays there while rsp_stall is high. The next byte is taken
// while a token waits; an item waits in its last cycle while a token is
// held in the output register by rsp_stall.
// csr_* writes window_size (always ready); write only while idle.
// Reset (synchronous, active high) empties the window, clears the phrase
// and sets window_size to 256. An end_of_input byte does the same, but
// window_size keeps its value.
`timescale 1ns / 1ps
`default_nettype none

module lz77_greedy_encoder #(
   parameter int WINDOW_MAX = lzg_pkg::WINDOW_MAX_DEFAULT
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire [lzg_pkg::BYTE_W-1:0]  req_data_byte,
   input  wire                        req_end_of_input,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output logic [lzg_pkg::OUT_W-1:0]  rsp_match_offset,
   output logic [lzg_pkg::OUT_W-1:0]  rsp_match_length,
   output logic [lzg_pkg::BYTE_W-1:0] rsp_literal_byte,
   output logic                       rsp_final_token,
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  wire [lzg_pkg::CFG_W-1:0]   csr_window_size
);
   import lzg_pkg::*;

   localparam int LEVELS = lzg_tree_levels(WINDOW_MAX);
   localparam int IDX_W  = 2 * LEVELS;
   localparam int FILL_W = $clog2(WINDOW_MAX + 1);
   localparam int EXT_W  = (FILL_W > CFG_W) ? FILL_W : CFG_W;
   localparam int CNT_W  = $clog2(LEVELS + 1);

   lzg_state_type      state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CFG_W-1:0]   ws_ff;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [FILL_W-1:0]  ps_ff, ps_in;
   logic [FILL_W-1:0]  plen_ff, plen_in;
   logic [FILL_W-1:0]  pend_ff, pend_in;
   logic [BYTE_W-1:0]  c_ff, c_in;
   logic               last_ff, last_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]   off_ff, off_in;
   logic [OUT_W-1:0]   len_ff, len_in;
   logic [BYTE_W-1:0]  lit_ff, lit_in;
   logic               fin_ff, fin_in;

   logic [FILL_W-1:0]  eff_size;
   logic               shift_en;
   logic [FILL_W-1:0]  phrase_len;
   logic [FILL_W-1:0]  fill_next;
   logic [FILL_W-1:0]  match_off;
   logic               out_free;
   lzg_cell_ctrl_type  ctrl;

   logic [BYTE_W-1:0]     w_q [WINDOW_MAX];
   logic [WINDOW_MAX-1:0] occ_q;
   logic [WINDOW_MAX-1:0] g_q;
   logic [WINDOW_MAX-1:0] live_q;
   logic                  tree_any;
   logic [IDX_W-1:0]      tree_idx;

   for (genvar q = 0; q < WINDOW_MAX; q++) begin : g_cell
      logic [BYTE_W-1:0] r_byte;
      logic              r_occ, r_flag, l_occ, l_flag;
      if (q == WINDOW_MAX - 1) begin : g_right_edge
         assign r_byte = '0;
         assign r_occ  = 1'b0;
         assign r_flag = 1'b0;
      end else begin : g_right
         assign r_byte = w_q[q+1];
         assign r_occ  = occ_q[q+1];
         assign r_flag = g_q[q+1];
      end
      if (q == 0) begin : g_left_edge
         assign l_occ  = 1'b1;
         assign l_flag = 1'b0;
      end else begin : g_left
         assign l_occ  = occ_q[q-1];
         assign l_flag = g_q[q-1];
      end
      // a match end counts only while its start is still in the window
      assign live_q[q] = g_q[q] && (FILL_W'(q + 1) >= phrase_len);
      lzg_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .right_byte (r_byte),
         .right_occ  (r_occ),
         .right_flag (r_flag),
         .left_occ   (l_occ),
         .left_flag  (l_flag),
         .cell_byte  (w_q[q]),
         .cell_occ   (occ_q[q]),
         .cell_flag  (g_q[q])
      );
   end

   lzg_max_tree #(
      .NUM_FLAGS (WINDOW_MAX)
   ) u_tree (
      .clock   (clock),
      .flags   (live_q),
      .any_set (tree_any),
      .top_idx (tree_idx)
   );

   always_comb begin
      if (ws_ff == '0) begin
         eff_size = FILL_W'(1);
      end else if (EXT_W'(ws_ff) > EXT_W'(WINDOW_MAX)) begin
         eff_size = FILL_W'(WINDOW_MAX);
      end else begin
         eff_size = FILL_W'(ws_ff);
      end
   end

   assign shift_en   = (fill_ff >= eff_size);
   assign phrase_len = fill_ff - ps_ff + FILL_W'(1);
   assign fill_next  = shift_en ? fill_ff : fill_ff + FILL_W'(1);
   assign match_off  = fill_ff - FILL_W'(tree_idx);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      fill_in      = fill_ff;
      ps_in        = ps_ff;
      plen_in      = plen_ff;
      pend_in      = pend_ff;
      c_in         = c_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      off_in       = off_ff;
      len_in       = len_ff;
      lit_in       = lit_ff;
      fin_in       = fin_ff;
      req_stall    = 1'b1;
      ctrl         = '0;
      ctrl.data    = c_ff;
      ctrl.first   = (ps_ff == fill_ff);
      ctrl.kill    = (ps_ff == '0);
      ctrl.shift   = shift_en;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            ctrl.data = req_data_byte;
            if (req_valid) begin
               ctrl.match = 1'b1;
               c_in       = req_data_byte;
               last_in    = req_end_of_input;
               cnt_in     = '0;
               state_in   = S_REDUCE;
            end
         end
         S_REDUCE: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(LEVELS - 1)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               ctrl.append = 1'b1;
               ctrl.clear  = last_ff;
               fill_in     = fill_next;
               if (tree_any) begin
                  pend_in = match_off;
                  plen_in = phrase_len;
                  if (shift_en && ps_ff != '0) begin
                     ps_in = ps_ff - FILL_W'(1);
                  end
                  if (last_ff) begin
                     rsp_valid_in = 1'b1;
                     off_in       = OUT_W'(match_off);
                     len_in       = OUT_W'(phrase_len - FILL_W'(1));
                     lit_in       = c_ff;
                     fin_in       = 1'b1;
                  end
               end else begin
                  rsp_valid_in = 1'b1;
                  off_in       = OUT_W'(pend_ff);
                  len_in       = OUT_W'(plen_ff);
                  lit_in       = c_ff;
                  fin_in       = last_ff;
                  pend_in      = '0;
                  plen_in      = '0;
                  ps_in        = fill_next;
               end
               if (last_ff) begin
                  fill_in = '0;
                  ps_in   = '0;
                  plen_in = '0;
                  pend_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         ws_ff        <= CFG_W'(CFG_RESET);
         fill_ff      <= '0;
         ps_ff        <= '0;
         plen_ff      <= '0;
         pend_ff      <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         fill_ff      <= fill_in;
         ps_ff        <= ps_in;
         plen_ff      <= plen_in;
         pend_ff      <= pend_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            ws_ff <= csr_window_size;
         end
      end
   end

   always_ff @(posedge clock) begin
      c_ff   <= c_in;
      off_ff <= off_in;
      len_ff <= len_in;
      lit_ff <= lit_in;
      fin_ff <= fin_in;
   end

   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_match_offset = off_ff;
   assign rsp_match_length = len_ff;
   assign rsp_literal_byte = lit_ff;
   assign rsp_final_token  = fin_ff;

   // phrase start always lies inside the filled window
   assert property (@(posedge clock) disable iff (reset) ps_ff <= fill_ff)
      else $error("phrase start beyond window fill");

   // a token only appears from the append cycle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("token loaded outside append cycle");

   // a taken byte starts the reduction
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_REDUCE))
      else $error("accepted byte did not start reduction");

   // end of input empties the window
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && last_ff && out_free) |=> (fill_ff == '0 && ps_ff == '0))
      else $error("stream state not cleared at end of input");

endmodule

`default_nettype wire

[test/lz77_greedy_encoder_test.sv]
// testbench of the lz77 greedy encoder: random and directed byte streams checked token by token
`timescale 1ns / 1ps

module lz77_greedy_encoder_test;
   import lzg_pkg::*;

   localparam int WINDOW_DEPTH  = 256;
   localparam int RANDOM_BYTES  = 1400;
   localparam int PHASE_BYTES   = 100;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 20;
   localparam int QUIET_LIMIT   = 4000;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } byte_item_type;

   typedef struct packed {
      logic [OUT_W-1:0]  offset;
      logic [OUT_W-1:0]  length;
      logic [BYTE_W-1:0] literal;
      logic              final_token;
   } lz_token_type;

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_stall;
   logic [BYTE_W-1:0] req_data_byte    = '0;
   logic              req_end_of_input = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall        = 1'b0;
   logic [OUT_W-1:0]  rsp_match_offset;
   logic [OUT_W-1:0]  rsp_match_length;
   logic [BYTE_W-1:0] rsp_literal_byte;
   logic              rsp_final_token;
   logic              csr_valid        = 1'b0;
   logic              csr_ready;
   logic [CFG_W-1:0]  csr_window_size  = '0;

   byte_item_type pending_bytes[$];
   lz_token_type  expected_tokens[$];

   // model of the window and the phrase in progress
   logic [BYTE_W-1:0] history [WINDOW_DEPTH];
   int unsigned       hist_fill   = 0;
   int unsigned       phrase_base = 0;
   int unsigned       phrase_len  = 0;
   int unsigned       match_dist  = 0;
   logic [CFG_W-1:0]  size_reg    = CFG_W'(CFG_RESET);

   int error_count    = 0;
   int tokens_checked = 0;
   int total_items    = 0;
   int streams_ended  = 0;
   int size_writes    = 0;
   int idle_pct       = 10;
   int hold_requests  = 0;
   int holds_served   = 0;
   int hold_left      = 0;
   int quiet_cycles   = 0;
   bit req_taken      = 1'b0;

   lz77_greedy_encoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_match_offset (rsp_match_offset),
      .rsp_match_length (rsp_match_length),
      .rsp_literal_byte (rsp_literal_byte),
      .rsp_final_token  (rsp_final_token),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_window_size  (csr_window_size)
   );

   always #2 clock = ~clock;

   function automatic int unsigned window_limit();
      if (size_reg == 0) begin
         return 1;
      end
      if (size_reg > WINDOW_DEPTH) begin
         return WINDOW_DEPTH;
      end
      return 32'(size_reg);
   endfunction

   // returns 1 when the oldest byte was shifted out
   function automatic bit push_history(input logic [BYTE_W-1:0] b);
      if (hist_fill < window_limit()) begin
         history[hist_fill] = b;
         hist_fill++;
         return 1'b0;
      end
      for (int unsigned i = 0; i + 1 < hist_fill; i++) begin
         history[i] = history[i + 1];
      end
      history[hist_fill - 1] = b;
      return 1'b1;
   endfunction

   function automatic void encode_byte(input logic [BYTE_W-1:0] c, input logic last);
      int unsigned  len;
      int unsigned  best;
      bit           found;
      bit           same;
      lz_token_type tok;
      found = 1'b0;
      best  = 0;
      if (phrase_base > hist_fill) begin
         phrase_base = hist_fill;
      end
      len = hist_fill - phrase_base + 1;
      if (hist_fill >= len) begin
         for (int unsigned p = 0; p + len <= hist_fill; p++) begin
            same = (history[p + len - 1] == c);
            for (int unsigned k = 0; k + 1 < len && same; k++) begin
               same = (history[p + k] == history[phrase_base + k]);
            end
            if (same) begin
               found = 1'b1;
               best  = p;
            end
         end
      end
      if (found) begin
         match_dist = phrase_base - best;
         phrase_len = len;
         if (push_history(c) && phrase_base > 0) begin
            phrase_base--;
         end
         // pending match flushed one byte short, the byte goes out as literal
         if (last) begin
            tok.offset      = OUT_W'(match_dist);
            tok.length      = OUT_W'(phrase_len - 1);
            tok.literal     = c;
            tok.final_token = 1'b1;
            expected_tokens.insert(expected_tokens.size(), tok);
         end
      end else begin
         tok.offset      = OUT_W'(match_dist);
         tok.length      = OUT_W'(phrase_len);
         tok.literal     = c;
         tok.final_token = last;
         expected_tokens.insert(expected_tokens.size(), tok);
         match_dist = 0;
         phrase_len = 0;
         void'(push_history(c));
         phrase_base = hist_fill;
      end
      if (last) begin
         hist_fill   = 0;
         phrase_base = 0;
         phrase_len  = 0;
         match_dist  = 0;
      end
   endfunction

   task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                              input logic [OUT_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // token check, byte prediction, register tracking and watchdog
   always @(posedge clock) begin : token_check
      lz_token_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_tokens.size() == 0) begin
               $error("token with none expected: offset %0d, length %0d, literal %0d",
                      rsp_match_offset, rsp_match_length, rsp_literal_byte);
               error_count++;
            end else begin
               want = expected_tokens.pop_front();
               check_field("match_offset", want.offset, rsp_match_offset);
               check_field("match_length", want.length, rsp_match_length);
               check_field("literal_byte", OUT_W'(want.literal), OUT_W'(rsp_literal_byte));
               check_field("final_token", OUT_W'(want.final_token), OUT_W'(rsp_final_token));
               tokens_checked++;
            end
         end
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            encode_byte(req_data_byte, req_end_of_input);
         end
         if (csr_valid && csr_ready) begin
            size_reg = csr_window_size;
         end
         if (req_taken || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no transfer for %0d cycles", QUIET_LIMIT);
            $display("lz77_greedy_encoder_test: errors");
            $finish;
         end
      end
   end

   always @(negedge clock) begin : byte_driver
      byte_item_type item;
      if (!req_valid || req_taken) begin
         if (pending_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
            item = pending_bytes.pop_front();
            req_valid        <= 1'b1;
            req_data_byte    <= item.data;
            req_end_of_input <= item.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (holds_served != hold_requests) begin
         holds_served = hold_requests;
         hold_left    = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < idle_pct);
      end
   end

   task automatic add_byte(input logic [BYTE_W-1:0] b, input logic last);
      byte_item_type item;
      item.data = b;
      item.last = last;
      pending_bytes.insert(pending_bytes.size(), item);
      total_items++;
      if (last) begin
         streams_ended++;
      end
   endtask

   task automatic add_text(input string s, input bit close);
      for (int i = 0; i < s.len(); i++) begin
         add_byte(s[i], close && i == s.len() - 1);
      end
   endtask

   // bytes drawn from a small alphabet so that matches are common
   task automatic add_run(input int n, input int alphabet, input bit close);
      logic [BYTE_W-1:0] base;
      base = 8'($urandom);
      for (int i = 0; i < n; i++) begin
         add_byte(base + 8'($urandom_range(alphabet - 1)), close && i == n - 1);
      end
   endtask

   task automatic add_noise(input int n);
      for (int i = 0; i < n; i++) begin
         add_byte(8'($urandom), $urandom_range(9) == 0);
      end
   endtask

   task automatic drain();
      do begin
         @(posedge clock);
         #1;
      end while (pending_bytes.size() != 0 || req_valid || expected_tokens.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      #1;
   endtask

   task automatic set_window(input logic [CFG_W-1:0] v);
      @(negedge clock);
      csr_valid       <= 1'b1;
      csr_window_size <= v;
      do @(posedge clock); while (csr_ready !== 1'b1);
      @(negedge clock);
      csr_valid <= 1'b0;
      size_writes++;
      @(posedge clock);
      #1;
   endtask

   function automatic logic [CFG_W-1:0] phase_size(input int phase);
      case (phase)
         0:       return 9'd256;
         1:       return 9'd1;
         2:       return 9'd64;
         3:       return 9'd0;
         4:       return 9'd511;
         5:       return 9'd2;
         6:       return 9'd255;
         7:       return 9'd257;
         8:       return 9'd8;
         default: return 9'($urandom_range(511));
      endcase
   endfunction

   initial begin
      int random_start;
      int target;
      int phase;
      int pick;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      #1;

      set_window(9'd256);
      add_byte(8'h00, 1'b1);
      add_text("AA", 1'b1);
      add_text("ABAB", 1'b1);
      add_text("ABAC", 1'b0);
      add_byte(8'hFF, 1'b1);
      drain();
      set_window(9'd0);
      add_text("AAB", 1'b1);
      drain();
      set_window(9'd511);
      add_text("XYXY", 1'b1);
      drain();
      // shrink the window below its fill in the middle of a stream
      set_window(9'd256);
      add_text("PQRST", 1'b0);
      drain();
      set_window(9'd2);
      add_text("PQR", 1'b1);
      drain();

      random_start = total_items;
      // full window of distinct bytes for the longest offset, then a run for the longest match
      set_window(9'd256);
      for (int i = 0; i < 256; i++) begin
         add_byte(8'(i), 1'b0);
      end
      add_byte(8'h00, 1'b0);
      add_byte(8'h33, 1'b1);
      add_run(260, 1, 1'b1);
      drain();

      phase = 0;
      while (total_items - random_start < RANDOM_BYTES) begin
         set_window(phase_size(phase));
         idle_pct = (phase == 4) ? 0 : 10;
         if (phase == 2) begin
            hold_requests++;
         end
         target = total_items + PHASE_BYTES;
         while (total_items < target) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
               add_run($urandom_range(40, 150), $urandom_range(1, 2), 1'b1);
            end else if (pick < 70) begin
               add_run($urandom_range(1, 40), $urandom_range(1, 4), 1'b1);
            end else if (pick < 85) begin
               add_run($urandom_range(1, 20), $urandom_range(1, 3), 1'b0);
            end else begin
               add_noise($urandom_range(1, 12));
            end
         end
         drain();
         phase++;
      end

      $display("sent %0d bytes closing %0d streams, checked %0d tokens",
               total_items, streams_ended, tokens_checked);
      $display("window size written %0d times from 0 to 511, output held off %0d cycles once",
               size_writes, HOLD_CYCLES);
      if (error_count == 0) begin
         $display("lz77_greedy_encoder_test: clean");
      end else begin
         $display("lz77_greedy_encoder_test: errors");
      end
      $finish;
   end

endmodule
